// ----- rtl/rc4pxc_pkg.sv -----
package rc4pxc_pkg;

    // Input word modes.
    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Length of the built-in key used when the key store is empty.
    localparam int ROM_KEY_LEN = 18;

    // Limits of the printable test on the XOR result: above the control range and not DEL.
    localparam logic [15:0] CTRL_LIMIT = 16'h001F;
    localparam logic [15:0] DEL_CODE   = 16'h007F;

    typedef logic [7:0] t_byte;

    // Low bytes of the built-in default key.
    function automatic t_byte rom_key_byte(input logic [4:0] idx);
        t_byte b;
        case (idx)
            5'd0:    b = 8'h54;
            5'd1:    b = 8'h65;
            5'd2:    b = 8'h73;
            5'd3:    b = 8'h74;
            5'd4:    b = 8'h20;
            5'd5:    b = 8'h4D;
            5'd6:    b = 8'h61;
            5'd7:    b = 8'h74;
            5'd8:    b = 8'h65;
            5'd9:    b = 8'hAE;
            5'd10:   b = 8'h20;
            5'd11:   b = 8'h50;
            5'd12:   b = 8'h72;
            5'd13:   b = 8'h6F;
            5'd14:   b = 8'h67;
            5'd15:   b = 8'h72;
            5'd16:   b = 8'h61;
            5'd17:   b = 8'h6D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // True when a character lies above the control range and is not DEL.
    function automatic logic is_printable(input logic [15:0] x);
        return (x > CTRL_LIMIT) && (x != DEL_CODE);
    endfunction

endpackage

// ----- rtl/rc4pxc_ram.sv -----
module rc4pxc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data is registered and held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rc4_printable_xor_cipher_unit.sv -----
// RC4-style stream cipher over 16-bit characters with a printable-result guard.
// The input channel (i_in_valid / o_in_ready) carries one word per character:
// a key character, a message character, or a clear-key command, chosen by
// i_mode. Only message characters produce a result word on the output channel
// (o_out_valid / i_out_ready). Key and clear words are taken without leaving idle.
// A message character runs the keystream states K0 to K5 before the next word
// is taken; its result is registered in K5. The permutation memory is used
// one access a cycle, with a registered read: three reads and two writes per
// character. A character flagged first of message first runs the key schedule:
// an identity fill of all 256 permutation entries followed by 256 swap steps,
// each through the states SA, SB, SC and SD.
// Reset clears the sequencer, the key count, the per-message offset and the
// output valid flag; the permutation and key memories are not cleared.
// The output word sits in a register, so a finished result may wait while
// the block already takes the next word. If the receiver stalls and a second
// result is ready, the sequencer holds in its last step until the register
// frees up; input ready stays low during that time.
module rc4_printable_xor_cipher_unit #(
    parameter int KEY_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_char_value,
    input  logic        i_first_of_message,
    input  logic        i_last_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_char,
    output logic        o_xor_applied,
    output logic        o_end_of_message
);

    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam int KPW = (KAW > 5) ? KAW : 5;
    localparam int KXW = KPW + 1;

    // Sequencer states. The schedule runs INIT then SA..SD per step; the
    // keystream for one character runs K0..K5.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_SA   = 4'd2;
    localparam logic [3:0] ST_SB   = 4'd3;
    localparam logic [3:0] ST_SC   = 4'd4;
    localparam logic [3:0] ST_SD   = 4'd5;
    localparam logic [3:0] ST_K0   = 4'd6;
    localparam logic [3:0] ST_K1   = 4'd7;
    localparam logic [3:0] ST_K2   = 4'd8;
    localparam logic [3:0] ST_K3   = 4'd9;
    localparam logic [3:0] ST_K4   = 4'd10;
    localparam logic [3:0] ST_K5   = 4'd11;

    logic [3:0]     r_state, n_state;
    logic [7:0]     r_cnt, n_cnt;
    logic [7:0]     r_n, n_n;
    logic [7:0]     r_i, n_i;
    logic [7:0]     r_j, n_j;
    logic [7:0]     r_a, n_a;
    logic [7:0]     r_o, n_o;
    logic [KPW-1:0] r_kpos, n_kpos;
    logic [KCW-1:0] r_key_count, n_key_count;
    logic [1:0]     r_offset, n_offset;
    logic [15:0]    r_ch, n_ch;
    logic           r_last, n_last;
    logic           r_out_valid, n_out_valid;
    logic [15:0]    r_out_char, n_out_char;
    logic           r_out_xor, n_out_xor;
    logic           r_out_end, n_out_end;

    logic           perm_we, perm_re;
    logic [7:0]     perm_waddr, perm_wdata, perm_raddr, perm_rdata;
    logic           key_we, key_re;
    logic [7:0]     key_rdata;

    logic           in_acc;
    logic [7:0]     key_byte, kb, sched_n, step_i, step_j;
    logic [KXW-1:0] kpos_inc;
    logic           kpos_wrap;
    logic [15:0]    xored;
    logic           apply;

    rc4pxc_ram #(
        .DEPTH(256),
        .WIDTH(8)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_re    (perm_re),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    rc4pxc_ram #(
        .DEPTH(KEY_DEPTH),
        .WIDTH(8)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_key_count[KAW-1:0]),
        .i_wdata (i_char_value[7:0]),
        .i_re    (key_re),
        .i_raddr (r_kpos[KAW-1:0]),
        .o_rdata (key_rdata)
    );

    assign in_acc = i_in_valid && (r_state == ST_IDLE);

    // Key byte for the current schedule step: the stored key, or the built-in
    // key when none has been loaded, plus the per-message offset.
    assign key_byte = (r_key_count != '0) ? key_rdata : rc4pxc_pkg::rom_key_byte(r_kpos[4:0]);
    assign kb       = key_byte + {6'b0, r_offset};
    assign sched_n  = r_n + perm_rdata + kb;

    assign kpos_inc  = {1'b0, r_kpos} + KXW'(1);
    assign kpos_wrap = (r_key_count != '0) ? (kpos_inc == KXW'(r_key_count))
                                           : (kpos_inc == KXW'(rc4pxc_pkg::ROM_KEY_LEN));

    assign step_i = r_i + 8'd1;
    assign step_j = r_j + perm_rdata;

    assign xored = r_ch ^ {8'h00, perm_rdata};
    assign apply = rc4pxc_pkg::is_printable(xored);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_o         = r_o;
        n_kpos      = r_kpos;
        n_key_count = r_key_count;
        n_offset    = r_offset;
        n_ch        = r_ch;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_out_xor   = r_out_xor;
        n_out_end   = r_out_end;
        perm_we     = 1'b0;
        perm_waddr  = r_cnt;
        perm_wdata  = r_cnt;
        perm_re     = 1'b0;
        perm_raddr  = r_cnt;
        key_we      = 1'b0;
        key_re      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        rc4pxc_pkg::MODE_KEY: begin
                            if (r_key_count < KCW'(KEY_DEPTH)) begin
                                key_we      = 1'b1;
                                n_key_count = r_key_count + KCW'(1);
                            end
                        end
                        rc4pxc_pkg::MODE_CLEAR: begin
                            n_key_count = '0;
                        end
                        rc4pxc_pkg::MODE_DATA: begin
                            n_ch   = i_char_value;
                            n_last = i_last_of_message;
                            if (i_first_of_message) begin
                                n_cnt   = 8'd0;
                                n_n     = 8'd0;
                                n_kpos  = '0;
                                n_state = ST_INIT;
                            end else begin
                                n_state = ST_K0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INIT: begin
                perm_we = 1'b1;
                n_cnt   = r_cnt + 8'd1;
                if (r_cnt == 8'hFF) begin
                    n_state = ST_SA;
                end
            end
            ST_SA: begin
                perm_re = 1'b1;
                key_re  = 1'b1;
                n_state = ST_SB;
            end
            ST_SB: begin
                n_a        = perm_rdata;
                n_n        = sched_n;
                perm_re    = 1'b1;
                perm_raddr = sched_n;
                n_kpos     = kpos_wrap ? '0 : kpos_inc[KPW-1:0];
                n_state    = ST_SC;
            end
            ST_SC: begin
                perm_we    = 1'b1;
                perm_wdata = perm_rdata;
                n_state    = ST_SD;
            end
            ST_SD: begin
                perm_we    = 1'b1;
                perm_waddr = r_n;
                perm_wdata = r_a;
                n_cnt      = r_cnt + 8'd1;
                if (r_cnt == 8'hFF) begin
                    n_i     = 8'd0;
                    n_j     = 8'd0;
                    n_state = ST_K0;
                end else begin
                    n_state = ST_SA;
                end
            end
            ST_K0: begin
                n_i        = step_i;
                perm_re    = 1'b1;
                perm_raddr = step_i;
                n_state    = ST_K1;
            end
            ST_K1: begin
                n_a        = perm_rdata;
                n_j        = step_j;
                perm_re    = 1'b1;
                perm_raddr = step_j;
                n_state    = ST_K2;
            end
            ST_K2: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = perm_rdata;
                n_o        = r_a + perm_rdata;
                n_state    = ST_K3;
            end
            ST_K3: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_a;
                n_state    = ST_K4;
            end
            ST_K4: begin
                perm_re    = 1'b1;
                perm_raddr = r_o;
                n_state    = ST_K5;
            end
            ST_K5: begin
                // Hold here while an earlier result still waits to be taken.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_char  = apply ? xored : r_ch;
                    n_out_xor   = apply;
                    n_out_end   = r_last;
                    if (r_last) begin
                        n_offset = r_offset + 2'd1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_count <= '0;
            r_offset    <= 2'd0;
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key_count <= n_key_count;
            r_offset    <= n_offset;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_n        <= n_n;
        r_a        <= n_a;
        r_o        <= n_o;
        r_kpos     <= n_kpos;
        r_ch       <= n_ch;
        r_last     <= n_last;
        r_out_char <= n_out_char;
        r_out_xor  <= n_out_xor;
        r_out_end  <= n_out_end;
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_char       = r_out_char;
    assign o_xor_applied    = r_out_xor;
    assign o_end_of_message = r_out_end;

endmodule

// ----- rtl/rc4pxc_checker.sv -----
module rc4pxc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_mode,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_out_char,
    input logic        o_xor_applied,
    input logic        o_end_of_message
);

    // A message word keeps the block busy, so input ready drops after it is accepted.
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode == rc4pxc_pkg::MODE_DATA) |=> !o_in_ready)
        else $error("input ready stayed high after a message word");

    // Key and clear words complete at once.
    a_cmd_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode != rc4pxc_pkg::MODE_DATA) |=> o_in_ready)
        else $error("input ready dropped after a key or clear word");

    // The XOR is reported only when it gives a printable character.
    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_xor_applied) |-> rc4pxc_pkg::is_printable(o_out_char))
        else $error("XOR flagged on a non-printable result");

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_char) && $stable(o_xor_applied)
             && $stable(o_end_of_message)))
        else $error("result word changed while stalled");

    // Reset leaves the block idle with no pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

endmodule

bind rc4_printable_xor_cipher_unit rc4pxc_checker u_rc4pxc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_mode             (i_mode),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_out_char         (o_out_char),
    .o_xor_applied      (o_xor_applied),
    .o_end_of_message   (o_end_of_message)
);
